FILE: design/lr_pkg.sv
// Line rasterizer package: widths, command codes and the structs that pass
// between the front end, the command queue and the pixel walker.
// No dependencies.
package lr_pkg;

    localparam int unsigned COORD_W         = 10;
    localparam int unsigned COLOR_W         = 24;
    localparam int unsigned OFFSET_W        = 22;
    localparam int unsigned ERR_W           = COORD_W + 2;
    localparam int unsigned ROW_PITCH_DEF   = 1024;
    localparam int unsigned BPP_DEF         = 3;
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } t_op;

    typedef struct packed {
        t_op                     op;
        logic [COORD_W-1:0]      start_x;
        logic [COORD_W-1:0]      start_y;
        logic [COORD_W-1:0]      goal_x;
        logic [COORD_W-1:0]      goal_y;
        logic [COORD_W-1:0]      span_x;
        logic [COORD_W-1:0]      span_y;
        logic                    dir_x_neg;
        logic                    dir_y_neg;
        logic signed [ERR_W-1:0] err_init;
        logic                    same;
        logic [COLOR_W-1:0]      color;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic busy;
        logic pop;
        t_op  op;
    } t_back_stat;

endpackage

FILE: design/lr_if.sv
// Line rasterizer channel interfaces: command words in, pixel words out.
// Depends on lr_pkg.
interface lr_cmd_if import lr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               command;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [COLOR_W-1:0] line_color;

    modport source (output valid, command, start_x, start_y, end_x, end_y, line_color,
                    input ready);
    modport sink   (input valid, command, start_x, start_y, end_x, end_y, line_color,
                    output ready);
endinterface

interface lr_pix_if import lr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [COORD_W-1:0]  pixel_x;
    logic [COORD_W-1:0]  pixel_y;
    logic [OFFSET_W-1:0] pixel_offset;
    logic [COLOR_W-1:0]  pixel_color;
    logic                last;

    modport source (output valid, pixel_x, pixel_y, pixel_offset, pixel_color, last,
                    input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_offset, pixel_color, last,
                    output ready);
endinterface

FILE: design/lr_front.sv
// Line rasterizer front end: accepts command words and decodes them into
// queue entries with spans, directions and initial error precomputed.
// Depends on lr_pkg and lr_if.
module lr_front import lr_pkg::*; (
    lr_cmd_if.sink  i_cmd,
    input  t_q_stat i_q_stat,
    output logic    o_push,
    output t_cmd    o_entry
);

    logic signed [COORD_W:0] w_dx;
    logic signed [COORD_W:0] w_dy;
    logic [COORD_W-1:0]      w_span_x;
    logic [COORD_W-1:0]      w_span_y;

    assign i_cmd.ready = !i_q_stat.full;
    assign o_push      = i_cmd.valid && !i_q_stat.full;

    always_comb begin
        w_dx     = $signed({1'b0, i_cmd.end_x}) - $signed({1'b0, i_cmd.start_x});
        w_dy     = $signed({1'b0, i_cmd.end_y}) - $signed({1'b0, i_cmd.start_y});
        w_span_x = w_dx[COORD_W] ? COORD_W'(-w_dx) : w_dx[COORD_W-1:0];
        w_span_y = w_dy[COORD_W] ? COORD_W'(-w_dy) : w_dy[COORD_W-1:0];

        o_entry.op        = t_op'(i_cmd.command);
        o_entry.start_x   = i_cmd.start_x;
        o_entry.start_y   = i_cmd.start_y;
        o_entry.goal_x    = i_cmd.end_x;
        o_entry.goal_y    = i_cmd.end_y;
        o_entry.span_x    = w_span_x;
        o_entry.span_y    = w_span_y;
        o_entry.dir_x_neg = !(i_cmd.start_x < i_cmd.end_x);
        o_entry.dir_y_neg = !(i_cmd.start_y < i_cmd.end_y);
        o_entry.err_init  = $signed({2'b00, w_span_x}) - $signed({2'b00, w_span_y});
        o_entry.same      = (i_cmd.start_x == i_cmd.end_x) && (i_cmd.start_y == i_cmd.end_y);
        o_entry.color     = i_cmd.line_color;
    end

endmodule

FILE: design/lr_queue.sv
// Line rasterizer command queue: short FIFO of decoded commands between the
// front end and the pixel walker.
// Depends on lr_pkg.
module lr_queue import lr_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_entry,
    input  logic    i_pop,
    output t_cmd    o_entry,
    output t_q_stat o_stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_entry      = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

FILE: design/lr_back.sv
// Line rasterizer back end: Bresenham walker that executes queued commands
// and holds each pixel word in an output register with its byte offset.
// Depends on lr_pkg and lr_if.
module lr_back import lr_pkg::*; #(
    parameter int unsigned ROW_PITCH       = ROW_PITCH_DEF,
    parameter int unsigned BYTES_PER_PIXEL = BPP_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_entry,
    input  t_q_stat    i_q_stat,
    output t_back_stat o_stat,
    lr_pix_if.source   o_pix
);

    localparam int unsigned ROW_BYTES = ROW_PITCH * BYTES_PER_PIXEL;

    logic [COORD_W-1:0]      r_cur_x, n_cur_x, r_cur_y, n_cur_y;
    logic [COORD_W-1:0]      r_goal_x, n_goal_x, r_goal_y, n_goal_y;
    logic [COORD_W-1:0]      r_span_x, n_span_x, r_span_y, n_span_y;
    logic                    r_dir_x_neg, n_dir_x_neg, r_dir_y_neg, n_dir_y_neg;
    logic signed [ERR_W-1:0] r_err, n_err;
    logic [COLOR_W-1:0]      r_color, n_color;
    logic                    r_busy, n_busy;

    logic                    r_out_valid, n_out_valid;
    logic [COORD_W-1:0]      r_px, r_py;
    logic [OFFSET_W-1:0]     r_off;
    logic [COLOR_W-1:0]      r_pcol;
    logic                    r_last;

    logic                    w_pop;
    logic signed [ERR_W:0]   w_e2, w_neg_span_y, w_err_sum;
    logic                    w_mv_x, w_mv_y, w_done;
    logic [COORD_W-1:0]      w_nx, w_ny;
    logic                    w_emit, w_elast;
    logic [COORD_W-1:0]      w_ex, w_ey;
    logic [COLOR_W-1:0]      w_ecol;
    logic [31:0]             w_off_full;

    assign w_pop = !i_q_stat.empty && (!r_out_valid || o_pix.ready);

    assign o_stat.busy = r_busy;
    assign o_stat.pop  = w_pop;
    assign o_stat.op   = i_entry.op;

    // Bresenham step from the current point
    always_comb begin
        w_e2         = {r_err, 1'b0};
        w_neg_span_y = $signed({(ERR_W + 1)'(0)}) - $signed({3'b000, r_span_y});
        w_mv_x       = (w_e2 > w_neg_span_y);
        w_mv_y       = (w_e2 < $signed({3'b000, r_span_x}));
        w_nx         = r_cur_x;
        w_ny         = r_cur_y;
        if (w_mv_x) begin
            w_nx = r_dir_x_neg ? r_cur_x - COORD_W'(1) : r_cur_x + COORD_W'(1);
        end
        if (w_mv_y) begin
            w_ny = r_dir_y_neg ? r_cur_y - COORD_W'(1) : r_cur_y + COORD_W'(1);
        end
        w_err_sum = {r_err[ERR_W-1], r_err}
                    - (w_mv_x ? $signed({3'b000, r_span_y}) : $signed((ERR_W + 1)'(0)))
                    + (w_mv_y ? $signed({3'b000, r_span_x}) : $signed((ERR_W + 1)'(0)));
        w_done    = (w_nx == r_goal_x) && (w_ny == r_goal_y);
    end

    always_comb begin
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_goal_x    = r_goal_x;
        n_goal_y    = r_goal_y;
        n_span_x    = r_span_x;
        n_span_y    = r_span_y;
        n_dir_x_neg = r_dir_x_neg;
        n_dir_y_neg = r_dir_y_neg;
        n_err       = r_err;
        n_color     = r_color;
        n_busy      = r_busy;
        w_emit      = 1'b0;
        w_ex        = r_cur_x;
        w_ey        = r_cur_y;
        w_elast     = w_done;
        w_ecol      = r_color;
        if (w_pop) begin
            case (i_entry.op)
                OP_START: begin
                    n_cur_x     = i_entry.start_x;
                    n_cur_y     = i_entry.start_y;
                    n_goal_x    = i_entry.goal_x;
                    n_goal_y    = i_entry.goal_y;
                    n_span_x    = i_entry.span_x;
                    n_span_y    = i_entry.span_y;
                    n_dir_x_neg = i_entry.dir_x_neg;
                    n_dir_y_neg = i_entry.dir_y_neg;
                    n_err       = i_entry.err_init;
                    n_color     = i_entry.color;
                    n_busy      = !i_entry.same;
                    w_emit      = 1'b1;
                    w_ex        = i_entry.goal_x;
                    w_ey        = i_entry.goal_y;
                    w_elast     = i_entry.same;
                    w_ecol      = i_entry.color;
                end
                OP_STEP: begin
                    // drop a step while idle
                    if (r_busy) begin
                        n_cur_x = w_nx;
                        n_cur_y = w_ny;
                        n_err   = w_err_sum[ERR_W-1:0];
                        n_busy  = !w_done;
                        w_emit  = 1'b1;
                    end
                end
                default: begin
                    w_emit = 1'b0;
                end
            endcase
        end
        n_out_valid = w_emit || (r_out_valid && !o_pix.ready);
    end

    assign w_off_full = 32'(w_ey) * 32'(ROW_BYTES) + 32'(w_ex) * 32'(BYTES_PER_PIXEL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur_x     <= n_cur_x;
        r_cur_y     <= n_cur_y;
        r_goal_x    <= n_goal_x;
        r_goal_y    <= n_goal_y;
        r_span_x    <= n_span_x;
        r_span_y    <= n_span_y;
        r_dir_x_neg <= n_dir_x_neg;
        r_dir_y_neg <= n_dir_y_neg;
        r_err       <= n_err;
        r_color     <= n_color;
        if (w_emit) begin
            r_px   <= w_ex;
            r_py   <= w_ey;
            r_off  <= w_off_full[OFFSET_W-1:0];
            r_pcol <= w_ecol;
            r_last <= w_elast;
        end
    end

    assign o_pix.valid        = r_out_valid;
    assign o_pix.pixel_x      = r_px;
    assign o_pix.pixel_y      = r_py;
    assign o_pix.pixel_offset = r_off;
    assign o_pix.pixel_color  = r_pcol;
    assign o_pix.last         = r_last;

endmodule

FILE: design/line_rasterizer_top.sv
// Line rasterizer top level: front end, command queue and Bresenham walker.
// Depends on lr_pkg, lr_if, lr_front, lr_queue and lr_back.
//
// Usage:
//   i_cmd carries command words. A start word (command 0) loads both end
//   points and a color and produces the end pixel at once, marked last when
//   the end points are equal. Each step word (command 1) produces the
//   current pixel and advances it, marked last when the advance reaches
//   the end point. A step while no line is active produces no pixel.
//   o_pix carries pixel words with column, row, byte offset
//   ((row * ROW_PITCH + column) * BYTES_PER_PIXEL, wrapped to 22 bits),
//   color and last.
//   Throughput: one command per cycle while o_pix.ready holds, set by the
//   walker step and the output register; the queue holds QUEUE_DEPTH
//   commands.
//   Reset: the queue empties, the walker goes idle and o_pix.valid drops.
//   Receiver stall: the output register holds its word, the queue fills,
//   and i_cmd.ready drops once the queue is full.
module line_rasterizer_top import lr_pkg::*; #(
    parameter int unsigned ROW_PITCH       = ROW_PITCH_DEF,
    parameter int unsigned BYTES_PER_PIXEL = BPP_DEF,
    parameter int unsigned QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    lr_cmd_if.sink   i_cmd,
    lr_pix_if.source o_pix
);

    t_q_stat    w_q_stat;
    t_back_stat w_back_stat;
    logic       w_push;
    t_cmd       w_push_entry;
    t_cmd       w_head_entry;

    lr_front u_front (
        .i_cmd    (i_cmd),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_entry  (w_push_entry)
    );

    lr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_back_stat.pop),
        .o_entry (w_head_entry),
        .o_stat  (w_q_stat)
    );

    lr_back #(
        .ROW_PITCH       (ROW_PITCH),
        .BYTES_PER_PIXEL (BYTES_PER_PIXEL)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_entry  (w_head_entry),
        .i_q_stat (w_q_stat),
        .o_stat   (w_back_stat),
        .o_pix    (o_pix)
    );

    a_idle_step_no_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_back_stat.pop && w_back_stat.op == OP_STEP && !w_back_stat.busy)
        |=> !o_pix.valid)
        else $error("step while idle produced a pixel");

    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && o_pix.last) |-> !w_back_stat.busy)
        else $error("walker still busy while last pixel is pending");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_stat.empty |-> !w_back_stat.pop)
        else $error("pop from empty command queue");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_pix.valid && !w_back_stat.busy))
        else $error("block not idle after reset");

endmodule
